@@ rtl/crcfr_pkg.sv @@
// Shared package for the CRC16 frame receiver.
// Holds the result type, the register codes, the reset values and the CRC16 byte update.
// Has no dependencies.
package crcfr_pkg;

    localparam int unsigned HeaderLen = 10;
    localparam int unsigned HdrIdxWidth = 4;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    localparam logic [7:0] StartFirstReset = 8'hAA;
    localparam logic [7:0] StartSecondReset = 8'h55;

    // Configuration register indexes
    localparam int unsigned CfgIndexWidth = 1;
    localparam logic [CfgIndexWidth-1:0] CfgStartFirst = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CfgStartSecond = 1'b1;

    // Event kinds
    localparam logic EvPayload = 1'b0;
    localparam logic EvFrame = 1'b1;

    typedef struct packed {
        logic        event_kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_version;
        logic [7:0]  command_code;
        logic [15:0] sequence_number;
        logic [31:0] target_address;
        logic [15:0] payload_length;
        logic        crc_good;
    } result_t;

    // CRC16-Modbus, reflected, one byte at a time
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CrcPoly;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/crcfr_parser.sv @@
// Frame parser: start byte hunt, header capture, payload streaming and CRC check.
// Produces at most one result per accepted byte, in the same cycle.
// Depends on crcfr_pkg.
module crcfr_parser
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_accept,
    input  logic [7:0]              rx_byte,
    input  logic [7:0]              start_first,
    input  logic [7:0]              start_second,
    output logic                    res_valid,
    output crcfr_pkg::result_t      res
);

    localparam logic [2:0] PhHunt0   = 3'd0;
    localparam logic [2:0] PhHunt1   = 3'd1;
    localparam logic [2:0] PhHeader  = 3'd2;
    localparam logic [2:0] PhPayload = 3'd3;
    localparam logic [2:0] PhCrc     = 3'd4;

    localparam logic [crcfr_pkg::HdrIdxWidth-1:0] HdrLast =
        crcfr_pkg::HdrIdxWidth'(crcfr_pkg::HeaderLen - 1);

    logic [2:0]                          phase_reg, phase_next;
    logic [crcfr_pkg::HdrIdxWidth-1:0]   hdr_count_reg, hdr_count_next;
    logic [15:0]                         pay_count_reg, pay_count_next;
    logic [15:0]                         crc_reg, crc_next;
    logic                                crc_cnt_reg, crc_cnt_next;
    logic [7:0]                          crc_low_reg;
    logic [7:0]                          hdr_reg [crcfr_pkg::HeaderLen];

    logic [15:0] crc_step;
    logic [15:0] pay_len;
    logic [15:0] pay_count_inc;
    logic [15:0] hdr_len_last;

    assign crc_step      = crcfr_pkg::crc16_update(crc_reg, rx_byte);
    assign pay_len       = {hdr_reg[9], hdr_reg[8]};
    assign pay_count_inc = pay_count_reg + 16'd1;
    assign hdr_len_last  = {rx_byte, hdr_reg[8]};

    // Work out the next state for the byte on the port
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        pay_count_next = pay_count_reg;
        crc_next       = crc_reg;
        crc_cnt_next   = crc_cnt_reg;
        case (phase_reg)
            PhHunt1:
            begin
                if (rx_byte == start_second)
                begin
                    crc_next       = crc_step;
                    hdr_count_next = '0;
                    phase_next     = PhHeader;
                end
                else
                begin
                    phase_next = PhHunt0;
                end
            end
            PhHeader:
            begin
                crc_next       = crc_step;
                hdr_count_next = hdr_count_reg + 1'b1;
                if (hdr_count_reg == HdrLast)
                begin
                    pay_count_next = '0;
                    crc_cnt_next   = 1'b0;
                    phase_next     = (hdr_len_last != 16'd0) ? PhPayload : PhCrc;
                end
            end
            PhPayload:
            begin
                crc_next       = crc_step;
                pay_count_next = pay_count_inc;
                if (pay_count_inc >= pay_len)
                begin
                    crc_cnt_next = 1'b0;
                    phase_next   = PhCrc;
                end
            end
            PhCrc:
            begin
                crc_cnt_next = ~crc_cnt_reg;
                if (crc_cnt_reg)
                begin
                    phase_next = PhHunt0;
                end
            end
            default:
            begin
                if (rx_byte == start_first)
                begin
                    crc_next   = crcfr_pkg::crc16_update(crcfr_pkg::CrcInit, rx_byte);
                    phase_next = PhHunt1;
                end
                else
                begin
                    phase_next = PhHunt0;
                end
            end
        endcase
    end

    // Build the result for this byte
    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;
        if (phase_reg == PhPayload)
        begin
            res_valid         = byte_accept;
            res.event_kind    = crcfr_pkg::EvPayload;
            res.payload_byte  = rx_byte;
            res.payload_index = pay_count_reg;
        end
        else if (phase_reg == PhCrc && crc_cnt_reg)
        begin
            res_valid           = byte_accept;
            res.event_kind      = crcfr_pkg::EvFrame;
            res.frame_version   = hdr_reg[0];
            res.command_code    = hdr_reg[1];
            res.sequence_number = {hdr_reg[3], hdr_reg[2]};
            res.target_address  = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
            res.payload_length  = pay_len;
            res.crc_good        = ({rx_byte, crc_low_reg} == crc_reg);
        end
    end

    // Advance control state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PhHunt0;
            hdr_count_reg <= '0;
            pay_count_reg <= '0;
            crc_reg       <= crcfr_pkg::CrcInit;
            crc_cnt_reg   <= 1'b0;
        end
        else if (byte_accept)
        begin
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            pay_count_reg <= pay_count_next;
            crc_reg       <= crc_next;
            crc_cnt_reg   <= crc_cnt_next;
        end
    end

    // Capture header bytes and the low CRC byte
    always_ff @(posedge clk)
    begin
        if (byte_accept && phase_reg == PhHeader)
        begin
            for (int i = 0; i < crcfr_pkg::HeaderLen; i++)
            begin
                if (hdr_count_reg == crcfr_pkg::HdrIdxWidth'(i))
                begin
                    hdr_reg[i] <= rx_byte;
                end
            end
        end
        if (byte_accept && phase_reg == PhCrc && !crc_cnt_reg)
        begin
            crc_low_reg <= rx_byte;
        end
    end

endmodule

@@ rtl/crc16_frame_receiver_unit.sv @@
// CRC16 frame receiver: top level with configuration registers and output buffering.
// Depends on crcfr_pkg and crcfr_parser.
//
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) carries one received byte per
//   transaction. Output channel (out_valid, out_stall and the result fields)
//   carries a payload byte event or a frame complete event with the header
//   fields and the CRC-good flag.
//   Each byte is parsed in the cycle it is accepted; its result is registered
//   into the output register, or the skid entry if stalled. One byte per cycle
//   is sustained while the skid is empty; CRC16 and phase logic are combinational.
//   The output register is backed by a one-entry skid buffer: bytes keep being
//   accepted while a result waits, and in_stall rises only once the skid entry
//   is occupied, so an output stall reaches the input through the registered skid flag.
//   cfg_we with cfg_index and cfg_data writes a start byte register; write
//   only while no frame is in flight.
//   Reset hunts for the first start byte, sets the start bytes to their
//   defaults (0xAA, 0x55) and empties the output and skid buffers.
module crc16_frame_receiver_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [crcfr_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                event_kind,
    output logic [7:0]                          payload_byte,
    output logic [15:0]                         payload_index,
    output logic [7:0]                          frame_version,
    output logic [7:0]                          command_code,
    output logic [15:0]                         sequence_number,
    output logic [31:0]                         target_address,
    output logic [15:0]                         payload_length,
    output logic                                crc_good
);

    logic [7:0] start_first_reg;
    logic [7:0] start_second_reg;

    logic               byte_accept;
    logic               res_valid;
    crcfr_pkg::result_t res;

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    crcfr_pkg::result_t out_reg, out_next;
    crcfr_pkg::result_t skid_reg, skid_next;

    assign in_stall    = skid_valid_reg;
    assign byte_accept = in_valid && !skid_valid_reg;

    // Hold the start byte registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= crcfr_pkg::StartFirstReset;
            start_second_reg <= crcfr_pkg::StartSecondReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                crcfr_pkg::CfgStartFirst:  start_first_reg  <= cfg_data;
                crcfr_pkg::CfgStartSecond: start_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    crcfr_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_accept  (byte_accept),
        .rx_byte      (rx_byte),
        .start_first  (start_first_reg),
        .start_second (start_second_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Steer results into the output register or the skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Drive the output ports
    assign out_valid       = out_valid_reg;
    assign event_kind      = out_reg.event_kind;
    assign payload_byte    = out_reg.payload_byte;
    assign payload_index   = out_reg.payload_index;
    assign frame_version   = out_reg.frame_version;
    assign command_code    = out_reg.command_code;
    assign sequence_number = out_reg.sequence_number;
    assign target_address  = out_reg.target_address;
    assign payload_length  = out_reg.payload_length;
    assign crc_good        = out_reg.crc_good;

endmodule
